FILE: src/ppi_pkg.sv
package ppi_pkg;

    localparam int PIXEL_W = 32;
    localparam int IDX_W   = 9;

    // control flags that travel with a pixel down the cell chain
    typedef struct packed {
        logic valid;
        logic clear;
        logic done;
        logic fresh;
    } tok_ctrl_t;

endpackage

FILE: src/ppi_pixel_if.sv
interface ppi_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [ppi_pkg::PIXEL_W-1:0]   pixel_value;
    logic                          first_of_image;

    modport source (output valid, output pixel_value, output first_of_image, input ready);
    modport sink (input valid, input pixel_value, input first_of_image, output ready);
endinterface

FILE: src/ppi_index_if.sv
interface ppi_index_if;
    logic                        valid;
    logic                        ready;
    logic [ppi_pkg::IDX_W-1:0]   colour_index;
    logic                        is_new_colour;
    logic                        table_overflow;
    logic [ppi_pkg::IDX_W-1:0]   colours_so_far;

    modport source (output valid, output colour_index, output is_new_colour,
                    output table_overflow, output colours_so_far, input ready);
    modport sink (input valid, input colour_index, input is_new_colour,
                  input table_overflow, input colours_so_far, output ready);
endinterface

FILE: src/ppi_cell.sv
module ppi_cell #(
    parameter int CELL_INDEX = 0,
    parameter int PIXEL_BITS = 32,
    parameter int IW         = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  ppi_pkg::tok_ctrl_t        ctrl_up,
    input  logic [PIXEL_BITS-1:0]     pix_up,
    input  logic [IW-1:0]             idx_up,
    input  logic [IW-1:0]             cnt_up,
    output ppi_pkg::tok_ctrl_t        ctrl_dn,
    output logic [PIXEL_BITS-1:0]     pix_dn,
    output logic [IW-1:0]             idx_dn,
    output logic [IW-1:0]             cnt_dn
);

    localparam logic [IW-1:0] MY_INDEX = IW'(CELL_INDEX + 1);

    logic [PIXEL_BITS-1:0] colour_reg;
    logic                  occ_reg;
    logic                  occ_next;
    ppi_pkg::tok_ctrl_t    ctrl_reg;
    ppi_pkg::tok_ctrl_t    ctrl_next;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         idx_next;
    logic [IW-1:0]         cnt_reg;
    logic [IW-1:0]         cnt_next;
    logic                  occ_eff;
    logic                  match;
    logic                  claim;

    // a clearing pixel empties each cell as it passes
    assign occ_eff = occ_reg && !ctrl_up.clear;
    assign match   = ctrl_up.valid && occ_eff && !ctrl_up.done && (colour_reg == pix_up);
    assign claim   = ctrl_up.valid && !occ_eff && !ctrl_up.done;

    always_comb
    begin
        ctrl_next       = ctrl_up;
        ctrl_next.done  = ctrl_up.done || match || claim;
        ctrl_next.fresh = ctrl_up.fresh || claim;
        idx_next        = (match || claim) ? MY_INDEX : idx_up;
        cnt_next        = cnt_up + IW'(occ_eff || claim);
        occ_next        = occ_reg;
        if (ctrl_up.valid)
        begin
            occ_next = occ_eff || claim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            occ_reg  <= occ_next;
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= pix_up;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            if (claim)
            begin
                colour_reg <= pix_up;
            end
        end
    end

    assign ctrl_dn = ctrl_reg;
    assign pix_dn  = pix_reg;
    assign idx_dn  = idx_reg;
    assign cnt_dn  = cnt_reg;

endmodule

FILE: src/pixel_palette_indexer_core.sv
// pixel palette indexer
// pixels carries one pixel a beat in raster order; first_of_image on a beat
// empties the color table before that pixel is looked up. labels returns
// one beat per pixel, in order: the 1-based palette index in order of first
// appearance, a new-color flag, an overflow flag (index 0, table full and
// color unseen) and the number of colors stored after that pixel.
// the table lives in a chain of MAX_COLOURS cells, one color each; a pixel
// steps one cell per cycle unless the chain holds, is compared in each, and
// claims the first empty cell if nothing matched. a later pixel trails its
// predecessor by at least one cell, so it always sees the colors that the
// earlier one appended. the result beat is registered after the last cell;
// a new pixel is taken every cycle while the chain does not hold.
// reset empties the table (occupancy flags clear) and drops all beats in
// flight. when the receiver stalls with a result waiting, the whole chain
// holds and pixels.ready falls in the same cycle; nothing is lost.
module pixel_palette_indexer_core #(
    parameter int MAX_COLOURS = 256,
    parameter int PIXEL_BITS  = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ppi_pixel_if.sink    pixels,
    ppi_index_if.source  labels
);

    localparam int IW    = $clog2(MAX_COLOURS + 1);
    localparam int OUT_W = ppi_pkg::IDX_W;
    localparam int PORT_W = ppi_pkg::PIXEL_W;

    ppi_pkg::tok_ctrl_t      ctrl_chain [MAX_COLOURS+1];
    logic [PIXEL_BITS-1:0]   pix_chain  [MAX_COLOURS+1];
    logic [IW-1:0]           idx_chain  [MAX_COLOURS+1];
    logic [IW-1:0]           cnt_chain  [MAX_COLOURS+1];

    logic                    en;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_index_reg;
    logic                    out_new_reg;
    logic                    out_over_reg;
    logic [OUT_W-1:0]        out_count_reg;
    ppi_pkg::tok_ctrl_t      last_ctrl;

    assign en           = !out_valid_reg || labels.ready;
    assign pixels.ready = en;

    generate
        if (PIXEL_BITS > PORT_W)
        begin : g_wide
            assign pix_chain[0] = {{(PIXEL_BITS-PORT_W){1'b0}}, pixels.pixel_value};
        end
        else
        begin : g_narrow
            assign pix_chain[0] = pixels.pixel_value[PIXEL_BITS-1:0];
        end
    endgenerate

    always_comb
    begin
        ctrl_chain[0]       = '0;
        ctrl_chain[0].valid = pixels.valid;
        ctrl_chain[0].clear = pixels.first_of_image;
    end

    assign idx_chain[0] = '0;
    assign cnt_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_COLOURS; gi++)
        begin : g_cell
            ppi_cell #(
                .CELL_INDEX (gi),
                .PIXEL_BITS (PIXEL_BITS),
                .IW         (IW)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .ctrl_up (ctrl_chain[gi]),
                .pix_up  (pix_chain[gi]),
                .idx_up  (idx_chain[gi]),
                .cnt_up  (cnt_chain[gi]),
                .ctrl_dn (ctrl_chain[gi+1]),
                .pix_dn  (pix_chain[gi+1]),
                .idx_dn  (idx_chain[gi+1]),
                .cnt_dn  (cnt_chain[gi+1])
            );
        end
    endgenerate

    assign last_ctrl = ctrl_chain[MAX_COLOURS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a pixel that ran off the end unresolved found the table full
            out_index_reg <= last_ctrl.done ? OUT_W'(idx_chain[MAX_COLOURS]) : '0;
            out_new_reg   <= last_ctrl.fresh;
            out_over_reg  <= !last_ctrl.done;
            out_count_reg <= OUT_W'(cnt_chain[MAX_COLOURS]);
        end
    end

    assign labels.valid          = out_valid_reg;
    assign labels.colour_index   = out_index_reg;
    assign labels.is_new_colour  = out_new_reg;
    assign labels.table_overflow = out_over_reg;
    assign labels.colours_so_far = out_count_reg;

endmodule

FILE: src/ppi_checker.sv
module ppi_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        valid,
    input logic                        ready,
    input logic [ppi_pkg::IDX_W-1:0]   colour_index,
    input logic                        is_new_colour,
    input logic                        table_overflow,
    input logic [ppi_pkg::IDX_W-1:0]   colours_so_far
);

    // a stalled result beat keeps its index, count and overflow flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(colour_index)
            && $stable(colours_so_far) && $stable(table_overflow))
        else $error("stalled result beat changed");

    // an appended color cannot also overflow
    a_new_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        valid && is_new_colour |-> !table_overflow)
        else $error("new color flagged as overflow");

    // an appended color takes the last index in the table
    a_new_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && is_new_colour |-> colour_index == colours_so_far)
        else $error("new color index differs from color count");

    // overflow gives index 0
    a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && table_overflow |-> colour_index == '0)
        else $error("overflow beat with nonzero index");

endmodule

bind pixel_palette_indexer_core ppi_checker u_ppi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (labels.valid),
    .ready          (labels.ready),
    .colour_index   (labels.colour_index),
    .is_new_colour  (labels.is_new_colour),
    .table_overflow (labels.table_overflow),
    .colours_so_far (labels.colours_so_far)
);

FILE: tb/sv/pixel_palette_indexer_core_test.sv
`timescale 1ns / 100ps

module pixel_palette_indexer_core_test;

    localparam int PIXEL_W         = ppi_pkg::PIXEL_W;
    localparam int IDX_W           = ppi_pkg::IDX_W;
    localparam int MAX_COLOURS     = 256;
    localparam int PIXEL_BITS      = 32;
    localparam int N_DIRECTED      = 17;
    localparam int RANDOM_PIXELS   = 1250;
    localparam int TOTAL_PIXELS    = N_DIRECTED + RANDOM_PIXELS;
    localparam int PRESSURE_CYCLES = 700;
    localparam logic [PIXEL_W-1:0] PIXEL_MASK = PIXEL_W'((64'd1 << PIXEL_BITS) - 1);

    typedef struct packed {
        logic [IDX_W-1:0] colour_index;
        logic             is_new_colour;
        logic             table_overflow;
        logic [IDX_W-1:0] colours_so_far;
    } label_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               first;
        logic               typed;
        label_t             label;
    } stim_row_t;

    typedef enum int {
        IMG_SMALL,
        IMG_MEDIUM,
        IMG_WIDE,
        IMG_NOISE
    } image_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ppi_pixel_if pixel_in ();
    ppi_index_if index_out ();

    pixel_palette_indexer_core #(
        .MAX_COLOURS (MAX_COLOURS),
        .PIXEL_BITS  (PIXEL_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixel_in),
        .labels (index_out)
    );

    // palette mirror
    logic [PIXEL_W-1:0] palette [MAX_COLOURS];
    int                 palette_size = 0;

    label_t expected_labels [$];

    int mismatch_count   = 0;
    int pixels_accepted  = 0;
    int idle_phase       = 0;
    bit pressure_done    = 1'b0;
    int images_started   = 0;
    int new_colours_seen = 0;
    int overflows_seen   = 0;
    int full_table_seen  = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // fresh after reset: no clear needed
        '{32'h0000_0000, 1'b0, 1'b1, '{9'd1, 1'b1, 1'b0, 9'd1}},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, '{9'd2, 1'b1, 1'b0, 9'd2}},
        '{32'h0000_0000, 1'b0, 1'b1, '{9'd1, 1'b0, 1'b0, 9'd2}},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, '{9'd2, 1'b0, 1'b0, 9'd2}},
        '{32'h8000_0000, 1'b0, 1'b1, '{9'd3, 1'b1, 1'b0, 9'd3}},
        '{32'h0000_0001, 1'b0, 1'b1, '{9'd4, 1'b1, 1'b0, 9'd4}},
        '{32'h0000_0001, 1'b0, 1'b1, '{9'd4, 1'b0, 1'b0, 9'd4}},
        // clear forgets every stored color
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{9'd1, 1'b1, 1'b0, 9'd1}},
        '{32'h0000_0000, 1'b0, 1'b1, '{9'd2, 1'b1, 1'b0, 9'd2}},
        '{32'h0000_0000, 1'b1, 1'b1, '{9'd1, 1'b1, 1'b0, 9'd1}},
        '{32'h0000_0000, 1'b1, 1'b1, '{9'd1, 1'b1, 1'b0, 9'd1}},
        '{32'h0000_0000, 1'b0, 1'b1, '{9'd1, 1'b0, 1'b0, 9'd1}},
        '{32'hA5A5_A5A5, 1'b0, 1'b0, '0},
        '{32'h5A5A_5A5A, 1'b0, 1'b0, '0},
        '{32'hA5A5_A5A5, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0}
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic queue_label(input label_t lbl);
        expected_labels = {expected_labels, lbl};
    endtask

    // looks the pixel up in the palette mirror and appends it when unseen
    function automatic label_t lookup_colour(input logic [PIXEL_W-1:0] pixel,
                                             input logic first);
        label_t             lbl;
        logic [PIXEL_W-1:0] key;
        int                 slot;
        key  = pixel & PIXEL_MASK;
        slot = 0;
        lbl  = '0;
        if (first)
            palette_size = 0;
        for (int i = 0; i < palette_size && slot == 0; i++)
            if (palette[i] == key)
                slot = i + 1;
        if (slot != 0)
        begin
            lbl.colour_index = IDX_W'(slot);
        end
        else if (palette_size < MAX_COLOURS)
        begin
            palette[palette_size] = key;
            palette_size++;
            lbl.colour_index  = IDX_W'(palette_size);
            lbl.is_new_colour = 1'b1;
        end
        else
        begin
            lbl.table_overflow = 1'b1;
        end
        lbl.colours_so_far = IDX_W'(palette_size);
        return lbl;
    endfunction

    task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic first,
                              input logic typed, input label_t typed_label);
        label_t predicted;
        int     idle_pct;
        idle_pct = (idle_phase == 0) ? 34 : (idle_phase == 1) ? 59 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            pixel_in.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_in.valid          <= 1'b1;
        pixel_in.pixel_value    <= pixel;
        pixel_in.first_of_image <= first;
        @(posedge clk);
        while (pixel_in.ready !== 1'b1)
            @(posedge clk);
        predicted = lookup_colour(pixel, first);
        queue_label(typed ? typed_label : predicted);
        if (first)
            images_started++;
        pixels_accepted++;
        idle_phase = (pixels_accepted * 3) / TOTAL_PIXELS;
        if (idle_phase > 2)
            idle_phase = 2;
    endtask

    // pixel source
    initial
    begin
        image_kind_t        kind;
        int                 length;
        int                 pool_size;
        int                 pick;
        logic [PIXEL_W-1:0] pool [MAX_COLOURS];
        logic [PIXEL_W-1:0] base;
        logic [PIXEL_W-1:0] pixel;
        logic               first;
        pixel_in.valid          <= 1'b0;
        pixel_in.pixel_value    <= '0;
        pixel_in.first_of_image <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (directed_rows[r])
            send_pixel(directed_rows[r].pixel, directed_rows[r].first,
                       directed_rows[r].typed, directed_rows[r].label);

        kind = IMG_WIDE;
        while (pixels_accepted < TOTAL_PIXELS)
        begin
            pool_size = 1;
            length    = 1;
            case (kind)
                IMG_SMALL:
                begin
                    pool_size = $urandom_range(24, 1);
                    length    = $urandom_range(48, 1);
                end
                IMG_MEDIUM:
                begin
                    pool_size = $urandom_range(MAX_COLOURS, 100);
                    length    = $urandom_range(320, 64);
                end
                IMG_WIDE:  length = $urandom_range(MAX_COLOURS + 44, MAX_COLOURS + 4);
                IMG_NOISE: length = $urandom_range(24, 1);
                default:   length = 1;
            endcase
            for (int p = 0; p < pool_size; p++)
                case ($urandom_range(7))
                    0:       pool[p] = '0;
                    1:       pool[p] = '1;
                    2:       pool[p] = PIXEL_W'(1) << $urandom_range(PIXEL_W - 1);
                    3:       pool[p] = ~(PIXEL_W'(1) << $urandom_range(PIXEL_W - 1));
                    default: pool[p] = $urandom;
                endcase
            base = $urandom;
            for (int i = 0; i < length && pixels_accepted < TOTAL_PIXELS; i++)
            begin
                first = (i == 0);
                case (kind)
                    IMG_WIDE:
                    begin
                        // odd multiplier keeps every index a distinct color;
                        // past the table size mix stored and unseen colors
                        if (i < MAX_COLOURS)
                            pick = i;
                        else if ($urandom_range(1))
                            pick = $urandom_range(MAX_COLOURS - 1);
                        else
                            pick = $urandom_range(2 * MAX_COLOURS - 1, MAX_COLOURS);
                        pixel = base ^ (PIXEL_W'(pick) * 32'h9E37_79B1);
                    end
                    IMG_NOISE:
                    begin
                        pixel = $urandom;
                        first = ($urandom_range(7) == 0);
                    end
                    default: pixel = pool[$urandom_range(pool_size - 1)];
                endcase
                send_pixel(pixel, first, 1'b0, '0);
            end
            pick = $urandom_range(99);
            kind = (pick < 55) ? IMG_SMALL : (pick < 75) ? IMG_MEDIUM :
                   (pick < 85) ? IMG_WIDE : IMG_NOISE;
        end
        pixel_in.valid <= 1'b0;

        while (expected_labels.size() != 0)
            @(posedge clk);
        // catch any stray beat still in the cell chain
        repeat (MAX_COLOURS + 16) @(posedge clk);

        $display("covered %0d pixels in %0d images, %0d new colors",
                 pixels_accepted, images_started, new_colours_seen);
        $display("full table beats %0d, overflow beats %0d, long output stall applied",
                 full_table_seen, overflows_seen);
        if (mismatch_count == 0)
            $display("pixel_palette_indexer_core_test: clean");
        else
            $display("pixel_palette_indexer_core_test: errors");
        $finish;
    end

    // index sink
    initial
    begin
        int     idle_pct;
        label_t want;
        index_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (idle_phase == 2 && !pressure_done)
            begin
                // hold off long enough for the chain to fill and stall the input
                pressure_done = 1'b1;
                index_out.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
            end
            idle_pct = (idle_phase == 0) ? 59 : (idle_phase == 1) ? 34 : 0;
            index_out.ready <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            if (index_out.valid === 1'b1 && index_out.ready === 1'b1)
            begin
                if (expected_labels.size() == 0)
                begin
                    report_mismatch("index beat with nothing expected");
                end
                else
                begin
                    want = expected_labels.pop_front();
                    if (index_out.colour_index !== want.colour_index)
                        report_mismatch($sformatf("colour_index got %0d want %0d",
                                        index_out.colour_index, want.colour_index));
                    if (index_out.is_new_colour !== want.is_new_colour)
                        report_mismatch($sformatf("is_new_colour got %b want %b",
                                        index_out.is_new_colour, want.is_new_colour));
                    if (index_out.table_overflow !== want.table_overflow)
                        report_mismatch($sformatf("table_overflow got %b want %b",
                                        index_out.table_overflow, want.table_overflow));
                    if (index_out.colours_so_far !== want.colours_so_far)
                        report_mismatch($sformatf("colours_so_far got %0d want %0d",
                                        index_out.colours_so_far, want.colours_so_far));
                    if (want.is_new_colour)
                        new_colours_seen++;
                    if (want.table_overflow)
                        overflows_seen++;
                    if (want.colours_so_far == IDX_W'(MAX_COLOURS))
                        full_table_seen++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("pixel_palette_indexer_core_test: errors");
        $finish;
    end

endmodule
